@@ design/jpeg_exif_orientation_parser_unit_defines.svh @@
// assertion macros used by the checker of the exif orientation parser
`ifndef JPEG_EXIF_ORIENTATION_PARSER_UNIT_DEFINES_SVH
`define JPEG_EXIF_ORIENTATION_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i
`define JEOP_ASSERT_IMP(lbl, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jeop check failed");

// next-cycle implication, sampled on clk_i
`define JEOP_ASSERT_NXT(lbl, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jeop check failed");

`endif

@@ design/jeop_pkg.sv @@
`timescale 1ns / 1ps

package jeop_pkg;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } jeop_item_t;

  typedef enum logic [4:0] {
    PH_SOI,
    PH_MARK,
    PH_APP1_LEN,
    PH_EXIF_ID,
    PH_APPN_LEN,
    PH_SKIP_APP,
    PH_ORDER,
    PH_VERSION,
    PH_IFD_OFS,
    PH_SKIP_IFD,
    PH_NTAG,
    PH_TAG,
    PH_SKIP_TAG,
    PH_TYPE,
    PH_COUNT,
    PH_VALUE,
    PH_DONE
  } jeop_phase_e;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StTrunc   = 3'd1;
  localparam logic [2:0] StNoExif  = 3'd2;
  localparam logic [2:0] StCorrupt = 3'd3;
  localparam logic [2:0] StBadOri  = 3'd4;

  localparam logic [15:0] MarkSoi        = 16'hffd8;
  localparam logic [15:0] MarkApp1       = 16'hffe1;
  localparam logic [11:0] MarkAppnHi     = 12'hffe;
  localparam logic [15:0] OrderMotorola  = 16'h4d4d;
  localparam logic [15:0] TiffVersion    = 16'h002a;
  localparam logic [15:0] TagOrientation = 16'h0112;
  localparam logic [15:0] TypeShort      = 16'h0003;
  localparam int          ExifIdLen      = 6;
  localparam int          TiffHdrLen     = 8;
  localparam int          EntryTailLen   = 10;
  localparam int          QueueDepth     = 4;

  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  // "Exif\0\0"
  function automatic logic [7:0] exif_id_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ design/jpeg_exif_orientation_parser_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  tdata                                    tlast
// s_axis    in   [7:0] data_byte                          last_byte
// m_axis    out  [2:0] status, [6:3] orientation, [7] 0   -
//
// one file byte per cycle sustained while the queue has room; a byte passes an input register, a
// four-entry queue and the parser, which registers the result.
// the parser takes one byte a cycle while the result register is free or drained.
// reset clears all control state at once; no clearing pass is needed.
// a stalled result holds the parser; the queue keeps taking bytes until full.
module jpeg_exif_orientation_parser_unit #(
  parameter int OffsetBits = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [2:0] status, [6:3] orientation, [7] zero
);
  import jeop_pkg::*;

  logic       push, full, pop, q_valid;
  jeop_item_t push_item, head_item;

  jeop_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_item_o      (push_item)
  );

  jeop_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  jeop_parser #(
    .OffsetBits (OffsetBits)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ design/jeop_front.sv @@
`timescale 1ns / 1ps

module jeop_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                q_full_i,
  output logic                q_push_o,
  output jeop_pkg::jeop_item_t q_item_o
);
  import jeop_pkg::*;

  logic       valid_q, valid_d;
  jeop_item_t item_q;
  logic       take;

  assign s_axis_tready = !valid_q || !q_full_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign q_push_o      = valid_q && !q_full_i;
  assign q_item_o      = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data <= s_axis_tdata;
      item_q.last <= s_axis_tlast;
    end
  end

endmodule

@@ design/jeop_queue.sv @@
`timescale 1ns / 1ps

module jeop_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jeop_pkg::jeop_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output jeop_pkg::jeop_item_t head_o
);
  import jeop_pkg::*;

  jeop_item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

@@ design/jeop_parser.sv @@
`timescale 1ns / 1ps

module jeop_parser #(
  parameter int OffsetBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  jeop_pkg::jeop_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata
);
  import jeop_pkg::*;

  localparam int SkipW = OffsetBits;
  localparam logic [31:0] OfsLimit =
      (OffsetBits >= 32) ? 32'h7fff_ffff : 32'((64'd1 << OffsetBits) - 64'd1);

  jeop_phase_e      phase_q, phase_d;
  logic [31:0]      fbuf_q, fbuf_d;
  logic [2:0]       fcnt_q, fcnt_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic             big_q, big_d;
  logic [15:0]      tags_q, tags_d;
  logic             id_bad_q, id_bad_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q;
  logic [3:0]       out_ori_q;

  logic             pop, out_free;
  logic [7:0]       b;
  logic             last;
  logic [31:0]      fbuf_sh;
  logic [2:0]       fcnt_inc;
  logic             done2, done4, id_end, bad_now;
  logic [15:0]      raw16, v16;
  logic [31:0]      v32;

  logic             res_hit;
  logic [2:0]       res_status;
  logic [3:0]       res_ori;

  assign out_free = !out_valid_q || m_axis_tready;
  assign pop      = q_valid_i && out_free;
  assign q_pop_o  = pop;
  assign b        = q_item_i.data;
  assign last     = q_item_i.last;

  assign fbuf_sh  = {fbuf_q[23:0], b};
  assign fcnt_inc = fcnt_q + 3'd1;
  assign done2    = (fcnt_inc >= 3'd2);
  assign done4    = (fcnt_inc >= 3'd4);
  assign id_end   = (fcnt_q == 3'(ExifIdLen - 1));
  assign bad_now  = id_bad_q || (b != exif_id_byte(fcnt_q));
  assign raw16    = fbuf_sh[15:0];
  assign v16      = big_q ? raw16 : {raw16[7:0], raw16[15:8]};
  assign v32      = big_q ? fbuf_sh
                          : {fbuf_sh[7:0], fbuf_sh[15:8], fbuf_sh[23:16], fbuf_sh[31:24]};

  // decision for the byte at the head of the queue
  always_comb begin
    res_hit    = 1'b0;
    res_status = StOk;
    res_ori    = 4'd0;
    case (phase_q)
      PH_SOI: begin
        if (done2 && raw16 != MarkSoi) begin
          res_hit = 1'b1; res_status = StTrunc;
        end
      end
      PH_MARK: begin
        if (done2 && raw16 != MarkApp1 && raw16[15:4] != MarkAppnHi) begin
          res_hit = 1'b1; res_status = StNoExif;
        end
      end
      PH_APPN_LEN: begin
        if (done2 && raw16 < 16'd2) begin
          res_hit = 1'b1; res_status = StCorrupt;
        end
      end
      PH_EXIF_ID: begin
        if (id_end && bad_now && skip_q < SkipW'(TiffHdrLen)) begin
          res_hit = 1'b1; res_status = StCorrupt;
        end
      end
      PH_VERSION: begin
        if (done2 && v16 != TiffVersion) begin
          res_hit = 1'b1; res_status = StCorrupt;
        end
      end
      PH_IFD_OFS: begin
        if (done4 && (v32 < 32'(TiffHdrLen) || v32 > OfsLimit)) begin
          res_hit = 1'b1; res_status = StCorrupt;
        end
      end
      PH_NTAG: begin
        // empty or negative entry count: no tag, default orientation
        if (done2 && (v16 == 16'd0 || v16[15])) begin
          res_hit = 1'b1; res_ori = 4'd1;
        end
      end
      PH_TAG: begin
        if (done2 && v16 != TagOrientation && tags_q == 16'd1) begin
          res_hit = 1'b1; res_ori = 4'd1;
        end
      end
      PH_TYPE: begin
        if (done2 && v16 != TypeShort) begin
          res_hit = 1'b1; res_status = StCorrupt;
        end
      end
      PH_COUNT: begin
        if (done4 && v32 != 32'd1) begin
          res_hit = 1'b1; res_status = StTrunc;
        end
      end
      PH_VALUE: begin
        if (done2) begin
          res_hit = 1'b1;
          if (v16 >= 16'd1 && v16 <= 16'd8) begin
            res_ori = v16[3:0];
          end else begin
            res_status = StBadOri;
          end
        end
      end
      default: begin
      end
    endcase
    // file ends before a decision; the byte that completes the byte order
    // already moves the parse into the version field
    if (!res_hit && last && phase_q != PH_DONE) begin
      res_hit = 1'b1;
      res_ori = 4'd0;
      if (phase_q inside {PH_SOI, PH_MARK, PH_APP1_LEN, PH_EXIF_ID, PH_APPN_LEN,
                          PH_SKIP_APP, PH_ORDER} && !(phase_q == PH_ORDER && done2)) begin
        res_status = StTrunc;
      end else begin
        res_status = StCorrupt;
      end
    end
    res_hit = res_hit && pop;
  end

  // next parse state
  always_comb begin
    phase_d  = phase_q;
    fbuf_d   = fbuf_q;
    fcnt_d   = fcnt_q;
    skip_d   = skip_q;
    big_d    = big_q;
    tags_d   = tags_q;
    id_bad_d = id_bad_q;
    if (pop) begin
      case (phase_q)
        PH_SOI, PH_MARK, PH_APPN_LEN, PH_APP1_LEN, PH_ORDER, PH_VERSION,
        PH_NTAG, PH_TAG, PH_TYPE, PH_VALUE: begin
          fbuf_d = fbuf_sh;
          fcnt_d = done2 ? 3'd0 : fcnt_inc;
        end
        PH_IFD_OFS, PH_COUNT: begin
          fbuf_d = fbuf_sh;
          fcnt_d = done4 ? 3'd0 : fcnt_inc;
        end
        default: begin
        end
      endcase
      case (phase_q)
        PH_SOI: begin
          if (done2) phase_d = PH_MARK;
        end
        PH_MARK: begin
          if (done2) phase_d = (raw16 == MarkApp1) ? PH_APP1_LEN : PH_APPN_LEN;
        end
        PH_APPN_LEN: begin
          if (done2) begin
            skip_d  = SkipW'(raw16 - 16'd2);
            phase_d = (raw16 == 16'd2) ? PH_MARK : PH_SKIP_APP;
          end
        end
        PH_APP1_LEN: begin
          if (done2) begin
            skip_d   = SkipW'(raw16);
            id_bad_d = 1'b0;
            phase_d  = PH_EXIF_ID;
          end
        end
        PH_EXIF_ID: begin
          id_bad_d = bad_now;
          fcnt_d   = id_end ? 3'd0 : fcnt_inc;
          if (id_end) begin
            if (bad_now) begin
              // not exif: skip the rest of the segment
              skip_d  = skip_q - SkipW'(TiffHdrLen);
              phase_d = (skip_q == SkipW'(TiffHdrLen)) ? PH_MARK : PH_SKIP_APP;
            end else begin
              phase_d = PH_ORDER;
            end
          end
        end
        PH_SKIP_APP, PH_SKIP_IFD, PH_SKIP_TAG: begin
          skip_d = skip_q - 1'b1;
          if (skip_q == SkipW'(1)) begin
            phase_d = (phase_q == PH_SKIP_APP) ? PH_MARK :
                      (phase_q == PH_SKIP_IFD) ? PH_NTAG : PH_TAG;
          end
        end
        PH_ORDER: begin
          if (done2) begin
            big_d   = (raw16 == OrderMotorola);
            phase_d = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (done2) phase_d = PH_IFD_OFS;
        end
        PH_IFD_OFS: begin
          // tiff header is always eight bytes long at this point
          if (done4) begin
            skip_d  = SkipW'(v32 - 32'(TiffHdrLen));
            phase_d = (v32 == 32'(TiffHdrLen)) ? PH_NTAG : PH_SKIP_IFD;
          end
        end
        PH_NTAG: begin
          if (done2) begin
            tags_d  = v16;
            phase_d = PH_TAG;
          end
        end
        PH_TAG: begin
          if (done2) begin
            tags_d = tags_q - 16'd1;
            if (v16 == TagOrientation) begin
              phase_d = PH_TYPE;
            end else begin
              skip_d  = SkipW'(EntryTailLen);
              phase_d = PH_SKIP_TAG;
            end
          end
        end
        PH_TYPE: begin
          if (done2) phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          if (done4) phase_d = PH_VALUE;
        end
        default: begin
        end
      endcase
      if (res_hit) begin
        phase_d = PH_DONE;
      end
      if (last) begin
        phase_d = PH_SOI;
        fcnt_d  = 3'd0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_hit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SOI;
      fcnt_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fbuf_q   <= fbuf_d;
    skip_q   <= skip_d;
    big_q    <= big_d;
    tags_q   <= tags_d;
    id_bad_q <= id_bad_d;
    if (res_hit) begin
      out_status_q <= res_status;
      out_ori_q    <= res_ori;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_ori_q, out_status_q};

endmodule

@@ design/jeop_checker.sv @@
`timescale 1ns / 1ps
`include "jpeg_exif_orientation_parser_unit_defines.svh"

module jeop_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import jeop_pkg::*;

  // a good result always carries a legal orientation
  `JEOP_ASSERT_IMP(a_ok_has_ori, rst_ni, m_axis_tvalid && m_axis_tdata[2:0] == StOk, m_axis_tdata[6:3] >= 4'd1 && m_axis_tdata[6:3] <= 4'd8)
  // any error clears the orientation
  `JEOP_ASSERT_IMP(a_err_no_ori, rst_ni, m_axis_tvalid && m_axis_tdata[2:0] != StOk, m_axis_tdata[6:3] == 4'd0)
  `JEOP_ASSERT_IMP(a_status_range, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] <= StBadOri && !m_axis_tdata[7])
  `JEOP_ASSERT_NXT(a_out_hold, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind jpeg_exif_orientation_parser_unit jeop_checker u_jeop_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
